### hdl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold at every edge out of reset
`define ASSERT_HOLDS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_HOLDS(label, clk, rst_n, prop)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### hdl/gtg_pkg.sv
`default_nettype none
package gtg_pkg;

	// default parameter values
	localparam int FRAC_BITS_DEF    = 12;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int SUM_WIDTH_DEF    = 32;

	// field widths
	localparam int POS_W       = 20;
	localparam int HEAD_W      = 16;
	localparam int WHEEL_W     = 12;
	localparam int SPD_LIM_W   = 13;
	localparam int TURN_LIM_W  = 14;
	localparam int GAIN_W      = 16;
	localparam int CFG_IDX_W   = 4;
	localparam int CFG_DATA_W  = 20;

	// cordic datapath
	localparam int XY_W        = 32;
	localparam int Z_W         = 28;
	localparam int SHIFT_W     = 5;
	localparam int GUARD_SH    = 8;
	localparam int ANG_FRAC    = 24;

	// angle and scale constants, q24 (INV_K_Q16 is q16)
	localparam int PI_Q24      = 52707179;
	localparam int TWO_PI_Q24  = 105414357;
	localparam int HALF_PI_Q24 = 26353589;
	localparam int INV_K_Q24   = 10188014;
	localparam int INV_K_Q16   = 39797;

	// wheel mixing: 2 * 1000 mm and 2 * 117.5 mm
	localparam int MIX_FWD     = 2000;
	localparam int MIX_TURN    = 235;
	localparam int WHEEL_SAT   = 2047;

	// register reset values
	localparam int GOAL_X_RST     = 2048;
	localparam int GOAL_Y_RST     = 2048;
	localparam int SPD_LIM_RST    = 819;
	localparam int TURN_LIM_RST   = 2145;
	localparam int SPD_GAIN_RST   = 3277;
	localparam int TURN_GP_RST    = 17408;
	localparam int TURN_GI_RST    = 410;
	localparam int INT_LIM_RST    = 1430;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GOAL_X         = 4'd0,
		REG_GOAL_Y         = 4'd1,
		REG_SPEED_LIMIT    = 4'd2,
		REG_TURN_LIMIT     = 4'd3,
		REG_SPEED_GAIN     = 4'd4,
		REG_TURN_GAIN_P    = 4'd5,
		REG_TURN_GAIN_I    = 4'd6,
		REG_INTEGRAL_LIMIT = 4'd7
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_VEC,
		ST_MAG,
		ST_WRAP,
		ST_SPEED,
		ST_PTERM,
		ST_ITERM,
		ST_TURN,
		ST_TURN_MUL,
		ST_COS_LOAD,
		ST_ROT,
		ST_FWD1,
		ST_FWD2,
		ST_FWD3,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic vectoring;
	} cordic_ctrl_t;

	// arctangent of 2^-i, q24
	function automatic logic signed [Z_W-1:0] atan_q24(input logic [SHIFT_W-1:0] idx);
		logic signed [Z_W-1:0] r;
		unique case (idx)
			5'd0:  r = 28'sd13176795;
			5'd1:  r = 28'sd7778716;
			5'd2:  r = 28'sd4110060;
			5'd3:  r = 28'sd2086331;
			5'd4:  r = 28'sd1047214;
			5'd5:  r = 28'sd524117;
			5'd6:  r = 28'sd262123;
			5'd7:  r = 28'sd131069;
			5'd8:  r = 28'sd65536;
			5'd9:  r = 28'sd32768;
			5'd10: r = 28'sd16384;
			5'd11: r = 28'sd8192;
			5'd12: r = 28'sd4096;
			5'd13: r = 28'sd2048;
			5'd14: r = 28'sd1024;
			5'd15: r = 28'sd512;
			5'd16: r = 28'sd256;
			5'd17: r = 28'sd128;
			5'd18: r = 28'sd64;
			5'd19: r = 28'sd32;
			5'd20: r = 28'sd16;
			5'd21: r = 28'sd8;
			5'd22: r = 28'sd4;
			5'd23: r = 28'sd2;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

### hdl/gtg_if.sv
`default_nettype none
// pose sample channel
interface gtg_pose_if;
	import gtg_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [POS_W-1:0]  pos_x;
	logic signed [POS_W-1:0]  pos_y;
	logic signed [HEAD_W-1:0] pose_heading;
	modport source (output valid, pos_x, pos_y, pose_heading, input ready);
	modport sink (input valid, pos_x, pos_y, pose_heading, output ready);
endinterface

// wheel command channel
interface gtg_wheel_if;
	import gtg_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [WHEEL_W-1:0] left_speed;
	logic signed [WHEEL_W-1:0] right_speed;
	logic                      arrived;
	logic                      spin_in_place;
	modport source (output valid, left_speed, right_speed, arrived, spin_in_place,
		input ready);
	modport sink (input valid, left_speed, right_speed, arrived, spin_in_place,
		output ready);
endinterface

// register write channel
interface gtg_cfg_if;
	import gtg_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### hdl/gtg_cordic.sv
`default_nettype none
module gtg_cordic (
	input  wire                                  clk,
	input  gtg_pkg::cordic_ctrl_t                ctrl,
	input  wire  [gtg_pkg::SHIFT_W-1:0]          shift,
	input  wire  signed [gtg_pkg::XY_W-1:0]      x_init,
	input  wire  signed [gtg_pkg::XY_W-1:0]      y_init,
	input  wire  signed [gtg_pkg::Z_W-1:0]       z_init,
	output logic signed [gtg_pkg::XY_W-1:0]      x,
	output logic signed [gtg_pkg::XY_W-1:0]      y,
	output logic signed [gtg_pkg::Z_W-1:0]       z
);
	import gtg_pkg::*;

	logic signed [XY_W-1:0] x_q, y_q, xs, ys;
	logic signed [Z_W-1:0]  z_q, ang;
	logic                   up;

	// one micro-rotation per cycle while ctrl.step is set
	always_comb begin
		xs  = x_q >>> shift;
		ys  = y_q >>> shift;
		ang = atan_q24(shift);
		up  = ctrl.vectoring ? y_q[XY_W-1] : !z_q[Z_W-1];
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			x_q <= x_init;
			y_q <= y_init;
			z_q <= z_init;
		end else if (ctrl.step) begin
			if (up) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - ang;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + ang;
			end
		end
	end

	assign x = x_q;
	assign y = y_q;
	assign z = z_q;
endmodule
`default_nettype wire

### hdl/gtg_mul.sv
`default_nettype none
module gtg_mul #(
	parameter int A_W = 40,
	parameter int B_W = 18
) (
	input  wire                      clk,
	input  wire                      en,
	input  wire  signed [A_W-1:0]    a,
	input  wire  signed [B_W-1:0]    b,
	output logic signed [A_W+B_W-1:0] prod
);
	logic signed [A_W+B_W-1:0] prod_q;

	// registered product, held while idle
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= a * b;
		end
	end

	assign prod = prod_q;
endmodule
`default_nettype wire

### hdl/go_to_goal_pi_steering.sv
// channel  dir  payload                                              handshake
// pose     in   pos_x, pos_y, pose_heading                           valid/ready
// wheel    out  left_speed, right_speed, arrived, spin_in_place      valid/ready
// cfg      in   index, data                                          valid/ready
//
// each pose sample runs through the shared cordic stage, which runs the vectoring
// pass and then the cosine pass; the heading wrap step repeats once per turn of
// the heading until it lies in range
// arrived and spin-in-place samples skip the cosine pass
// arst_n clears the sequencer, the error sum and the registers to their reset values
// a result waiting on the wheel channel holds the sequencer in its last step
`default_nettype none
`include "assert_macros.svh"
module go_to_goal_pi_steering #(
	parameter int FRAC_BITS    = gtg_pkg::FRAC_BITS_DEF,
	parameter int CORDIC_STEPS = gtg_pkg::CORDIC_STEPS_DEF,
	parameter int SUM_WIDTH    = gtg_pkg::SUM_WIDTH_DEF
) (
	input wire          clk,
	input wire          arst_n,
	gtg_pose_if.sink    pose,
	gtg_wheel_if.source wheel,
	gtg_cfg_if.sink     cfg
);
	import gtg_pkg::*;

	localparam int CNT_W    = $clog2(CORDIC_STEPS);
	localparam int HD_SH    = ANG_FRAC - FRAC_BITS;
	localparam int DIFF_W   = ((HEAD_W + HD_SH > Z_W - 1) ? HEAD_W + HD_SH : Z_W - 1) + 2;
	localparam int HF_W     = FRAC_BITS + 3;
	localparam int SE_W     = ((SUM_WIDTH > HF_W) ? SUM_WIDTH : HF_W) + 1;
	localparam int DX_W     = POS_W + 1;
	localparam int DIST_W   = 24;
	localparam int A_W      = (SUM_WIDTH > 40) ? SUM_WIDTH : 40;
	localparam int B_W      = 18;
	localparam int P_W      = A_W + B_W;
	localparam int WP_W     = 20;
	localparam int WI_W     = 15;
	localparam int W_W      = 15;
	localparam int TURN_W   = 24;
	localparam int MIX_W    = 53;
	localparam int MIX_SH   = FRAC_BITS + 25;
	localparam int ARRIVE   = (5 * (1 << FRAC_BITS) + 50) / 100;

	localparam logic [CNT_W-1:0]        CNT_LAST = CNT_W'(CORDIC_STEPS - 1);
	localparam logic signed [DIFF_W-1:0] PI_D     = DIFF_W'(PI_Q24);
	localparam logic signed [DIFF_W-1:0] TWO_PI_D = DIFF_W'(TWO_PI_Q24);
	localparam logic signed [DIFF_W-1:0] HALF_PI_D = DIFF_W'(HALF_PI_Q24);
	localparam logic signed [DIFF_W-1:0] HF_HALF  = DIFF_W'(1) <<< (HD_SH - 1);
	localparam logic signed [P_W-1:0]    MAG_HALF = P_W'(1) <<< (ANG_FRAC - 1);
	localparam logic signed [SE_W-1:0]   SMAX     = (SE_W'(1) <<< (SUM_WIDTH - 1)) - SE_W'(1);
	localparam logic signed [MIX_W-1:0]  MIX_HALF = MIX_W'(1) <<< (MIX_SH - 1);
	localparam logic signed [MIX_W-1:0]  SAT_POS  = MIX_W'(WHEEL_SAT);
	localparam logic signed [DIST_W-1:0] ARRIVE_D = DIST_W'(ARRIVE);

	// control state
	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic signed [SUM_WIDTH-1:0] sum_q;
	logic out_valid_q;

	// registers
	logic signed [POS_W-1:0]    goal_x_q, goal_y_q;
	logic [SPD_LIM_W-1:0]       speed_limit_q;
	logic [TURN_LIM_W-1:0]      turn_limit_q, integral_limit_q;
	logic [GAIN_W-1:0]          speed_gain_q, turn_gain_p_q, turn_gain_i_q;

	// payload
	logic signed [POS_W-1:0]    pos_x_q, pos_y_q;
	logic signed [HEAD_W-1:0]   hd_q;
	logic signed [DIFF_W-1:0]   h_q;
	logic signed [DIST_W-1:0]   dist_q;
	logic signed [HF_W-1:0]     hf_q;
	logic [SPD_LIM_W-1:0]       v_q;
	logic signed [WP_W-1:0]     wp_q;
	logic signed [W_W-1:0]      w_q;
	logic signed [TURN_W-1:0]   turn_q;
	logic signed [MIX_W-1:0]    fwd_q;
	logic signed [WHEEL_W-1:0]  left_q, right_q;
	logic                       arrived_q, spin_q;

	// shared units
	cordic_ctrl_t            cctrl;
	logic signed [XY_W-1:0]  cx_init, cy_init, cx, cy;
	logic signed [Z_W-1:0]   cz_init, cz;
	logic                    mul_en;
	logic signed [A_W-1:0]   mul_a;
	logic signed [B_W-1:0]   mul_b;
	logic signed [P_W-1:0]   prod;

	// combinational helpers
	logic signed [DX_W-1:0]  dx, dy;
	logic signed [XY_W-1:0]  xg, yg;
	logic                    cnt_done, wrap_hi, wrap_lo, is_arrived, is_spin, out_free;
	logic signed [P_W-1:0]   v_full, wi_full;
	logic signed [SE_W-1:0]  sum_ext;
	logic signed [WI_W-1:0]  wi;
	logic signed [WP_W:0]    wsum;
	logic signed [MIX_W-1:0] turn_sh, mix_l, mix_r, rl, rr;

	gtg_cordic u_cordic (
		.clk    (clk),
		.ctrl   (cctrl),
		.shift  (SHIFT_W'(cnt_q)),
		.x_init (cx_init),
		.y_init (cy_init),
		.z_init (cz_init),
		.x      (cx),
		.y      (cy),
		.z      (cz)
	);

	gtg_mul #(.A_W(A_W), .B_W(B_W)) u_mul (
		.clk  (clk),
		.en   (mul_en),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	// goal difference and status decodes
	always_comb begin
		dx         = DX_W'(goal_x_q) - DX_W'(pos_x_q);
		dy         = DX_W'(goal_y_q) - DX_W'(pos_y_q);
		xg         = XY_W'(dx) <<< GUARD_SH;
		yg         = XY_W'(dy) <<< GUARD_SH;
		cnt_done   = (cnt_q == CNT_LAST);
		wrap_hi    = (h_q > PI_D);
		wrap_lo    = (h_q <= -PI_D);
		is_arrived = (dist_q <= ARRIVE_D);
		is_spin    = !((h_q < HALF_PI_D) && (h_q > -HALF_PI_D));
		out_free   = !out_valid_q || wheel.ready;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (pose.valid) state_d = ST_LOAD;
			ST_LOAD:     state_d = (dx == '0 && dy == '0) ? ST_MAG : ST_VEC;
			ST_VEC:      if (cnt_done) state_d = ST_MAG;
			ST_MAG:      state_d = ST_WRAP;
			ST_WRAP:     if (!wrap_hi && !wrap_lo) state_d = ST_SPEED;
			ST_SPEED:    state_d = ST_PTERM;
			ST_PTERM:    state_d = ST_ITERM;
			ST_ITERM:    state_d = ST_TURN;
			ST_TURN:     state_d = ST_TURN_MUL;
			ST_TURN_MUL: state_d = ST_COS_LOAD;
			ST_COS_LOAD: state_d = (is_arrived || is_spin) ? ST_OUT : ST_ROT;
			ST_ROT:      if (cnt_done) state_d = ST_FWD1;
			ST_FWD1:     state_d = ST_FWD2;
			ST_FWD2:     state_d = ST_FWD3;
			ST_FWD3:     state_d = ST_OUT;
			ST_OUT:      if (out_free) state_d = ST_IDLE;
		endcase
	end

	// unit controls and operand selection
	always_comb begin
		pose.ready = (state_q == ST_IDLE);
		cfg.ready  = 1'b1;
		cctrl      = '0;
		cx_init    = '0;
		cy_init    = '0;
		cz_init    = '0;
		mul_en     = 1'b0;
		mul_a      = '0;
		mul_b      = '0;
		unique case (state_q)
			ST_LOAD: begin
				cctrl.load = 1'b1;
				if (dx == '0 && dy == '0) begin
					cx_init = '0;
					cy_init = '0;
					cz_init = '0;
				end else if (dx < 0) begin
					cx_init = -xg;
					cy_init = -yg;
					cz_init = (dy >= 0) ? Z_W'(PI_Q24) : -Z_W'(PI_Q24);
				end else begin
					cx_init = xg;
					cy_init = yg;
				end
			end
			ST_VEC: begin
				cctrl.step      = 1'b1;
				cctrl.vectoring = 1'b1;
			end
			ST_MAG: begin
				mul_en = 1'b1;
				mul_a  = A_W'(cx);
				mul_b  = B_W'(INV_K_Q16);
			end
			ST_SPEED: begin
				mul_en = 1'b1;
				mul_a  = A_W'(dist_q);
				mul_b  = signed'(B_W'(speed_gain_q));
			end
			ST_PTERM: begin
				mul_en = 1'b1;
				mul_a  = A_W'(hf_q);
				mul_b  = signed'(B_W'(turn_gain_p_q));
			end
			ST_ITERM: begin
				mul_en = 1'b1;
				mul_a  = A_W'(sum_q);
				mul_b  = signed'(B_W'(turn_gain_i_q));
			end
			ST_TURN_MUL: begin
				mul_en = 1'b1;
				mul_a  = A_W'(w_q);
				mul_b  = B_W'(MIX_TURN);
			end
			ST_COS_LOAD: begin
				cctrl.load = 1'b1;
				cx_init    = XY_W'(INV_K_Q24);
				cy_init    = '0;
				cz_init    = Z_W'(h_q);
			end
			ST_ROT: begin
				cctrl.step = 1'b1;
			end
			ST_FWD1: begin
				mul_en = 1'b1;
				mul_a  = A_W'(cx);
				mul_b  = signed'(B_W'(v_q));
			end
			ST_FWD2: begin
				mul_en = 1'b1;
				mul_a  = prod[A_W-1:0];
				mul_b  = B_W'(MIX_FWD);
			end
			default: begin
			end
		endcase
	end

	// product scaling, clamps and wheel mix
	always_comb begin
		v_full  = prod >>> FRAC_BITS;
		wi_full = prod >>> FRAC_BITS;
		sum_ext = SE_W'(sum_q) + SE_W'(hf_q);
		if (wi_full > signed'(P_W'(integral_limit_q))) begin
			wi = signed'(WI_W'(integral_limit_q));
		end else if (wi_full < -signed'(P_W'(integral_limit_q))) begin
			wi = -signed'(WI_W'(integral_limit_q));
		end else begin
			wi = WI_W'(wi_full);
		end
		wsum    = (WP_W + 1)'(wp_q) + (WP_W + 1)'(wi);
		turn_sh = MIX_W'(turn_q) <<< ANG_FRAC;
		mix_l   = (fwd_q + turn_sh + MIX_HALF) >>> MIX_SH;
		mix_r   = (fwd_q - turn_sh + MIX_HALF) >>> MIX_SH;
		if (mix_l > SAT_POS) rl = SAT_POS;
		else if (mix_l < -SAT_POS) rl = -SAT_POS;
		else rl = mix_l;
		if (mix_r > SAT_POS) rr = SAT_POS;
		else if (mix_r < -SAT_POS) rr = -SAT_POS;
		else rr = mix_r;
	end

	// sequencer, step counter, error sum, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_VEC || state_q == ST_ROT) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else begin
				cnt_q <= '0;
			end
			if (state_q == ST_PTERM) begin
				if (sum_ext > SMAX) sum_q <= SUM_WIDTH'(SMAX);
				else if (sum_ext < -SMAX) sum_q <= SUM_WIDTH'(-SMAX);
				else sum_q <= SUM_WIDTH'(sum_ext);
			end
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (wheel.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_x_q         <= POS_W'(GOAL_X_RST);
			goal_y_q         <= POS_W'(GOAL_Y_RST);
			speed_limit_q    <= SPD_LIM_W'(SPD_LIM_RST);
			turn_limit_q     <= TURN_LIM_W'(TURN_LIM_RST);
			speed_gain_q     <= GAIN_W'(SPD_GAIN_RST);
			turn_gain_p_q    <= GAIN_W'(TURN_GP_RST);
			turn_gain_i_q    <= GAIN_W'(TURN_GI_RST);
			integral_limit_q <= TURN_LIM_W'(INT_LIM_RST);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_GOAL_X:         goal_x_q         <= signed'(cfg.data);
				REG_GOAL_Y:         goal_y_q         <= signed'(cfg.data);
				REG_SPEED_LIMIT:    speed_limit_q    <= cfg.data[SPD_LIM_W-1:0];
				REG_TURN_LIMIT:     turn_limit_q     <= cfg.data[TURN_LIM_W-1:0];
				REG_SPEED_GAIN:     speed_gain_q     <= cfg.data[GAIN_W-1:0];
				REG_TURN_GAIN_P:    turn_gain_p_q    <= cfg.data[GAIN_W-1:0];
				REG_TURN_GAIN_I:    turn_gain_i_q    <= cfg.data[GAIN_W-1:0];
				REG_INTEGRAL_LIMIT: integral_limit_q <= cfg.data[TURN_LIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				pos_x_q <= pose.pos_x;
				pos_y_q <= pose.pos_y;
				hd_q    <= pose.pose_heading;
			end
			ST_MAG: begin
				h_q <= DIFF_W'(cz) - (DIFF_W'(hd_q) <<< HD_SH);
			end
			ST_WRAP: begin
				dist_q <= DIST_W'((prod + MAG_HALF) >>> ANG_FRAC);
				if (wrap_hi) h_q <= h_q - TWO_PI_D;
				else if (wrap_lo) h_q <= h_q + TWO_PI_D;
			end
			ST_SPEED: begin
				hf_q <= HF_W'((h_q + HF_HALF) >>> HD_SH);
			end
			ST_PTERM: begin
				if (v_full > signed'(P_W'(speed_limit_q))) v_q <= speed_limit_q;
				else v_q <= SPD_LIM_W'(v_full);
			end
			ST_ITERM: begin
				wp_q <= WP_W'(prod >>> FRAC_BITS);
			end
			ST_TURN: begin
				if (wsum > signed'((WP_W + 1)'(turn_limit_q))) begin
					w_q <= signed'(W_W'(turn_limit_q));
				end else if (wsum < -signed'((WP_W + 1)'(turn_limit_q))) begin
					w_q <= -signed'(W_W'(turn_limit_q));
				end else begin
					w_q <= W_W'(wsum);
				end
			end
			ST_COS_LOAD: begin
				turn_q <= TURN_W'(prod);
				fwd_q  <= '0;
			end
			ST_FWD3: begin
				fwd_q <= MIX_W'(prod);
			end
			ST_OUT: begin
				if (out_free) begin
					if (is_arrived) begin
						left_q    <= '0;
						right_q   <= '0;
						arrived_q <= 1'b1;
						spin_q    <= 1'b0;
					end else begin
						left_q    <= WHEEL_W'(rl);
						right_q   <= WHEEL_W'(rr);
						arrived_q <= 1'b0;
						spin_q    <= is_spin;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// result word
	assign wheel.valid         = out_valid_q;
	assign wheel.left_speed    = left_q;
	assign wheel.right_speed   = right_q;
	assign wheel.arrived       = arrived_q;
	assign wheel.spin_in_place = spin_q;

	// checks
	`ASSERT_IMPLIES(a_arrived_stops, clk, arst_n, wheel.valid && wheel.arrived,
		wheel.left_speed == '0 && wheel.right_speed == '0 && !wheel.spin_in_place)
	`ASSERT_NEXT(a_cordic_count, clk, arst_n, state_q == ST_VEC && !cnt_done,
		state_q == ST_VEC && cnt_q == $past(cnt_q) + CNT_W'(1))
	`ASSERT_HOLDS(a_sum_sym, clk, arst_n,
		sum_q != {1'b1, {(SUM_WIDTH - 1){1'b0}}})
	`ASSERT_IMPLIES(a_wheel_sat, clk, arst_n, wheel.valid,
		wheel.left_speed != {1'b1, {(WHEEL_W - 1){1'b0}}} &&
		wheel.right_speed != {1'b1, {(WHEEL_W - 1){1'b0}}})

endmodule
`default_nettype wire
